FILE: design/websocket_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// WebSocket frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_PARSER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WSFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Widths, result kinds and header constants shared by the parser modules.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  localparam int LEN_W = 64;
  localparam int OUT_LEN_W = 64;
  localparam int CNT_W = 4;

  localparam logic [6:0] LEN7_MASK = 7'h7F;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] OPCODE_MASK = 4'hF;

  localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [CNT_W-1:0] KEY_BYTES = 4'd4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

endpackage

FILE: design/wsfp_in_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser input channel
// Valid/ready channel carrying one raw buffer byte per transfer.
// ----------------------------------------------------------------------------
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

FILE: design/wsfp_out_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser result channel
// Valid/ready channel carrying one parsed result per transfer.
// ----------------------------------------------------------------------------
interface wsfp_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic                           fin;
  logic [3:0]                     opcode;
  logic                           masked;
  logic [wsfp_pkg::OUT_LEN_W-1:0] frame_len;
  logic [7:0]                     payload_byte;
  logic                           last;

  modport source (output valid, output kind, output fin, output opcode, output masked,
                  output frame_len, output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input fin, input opcode, input masked,
                input frame_len, input payload_byte, input last, output ready);
endinterface

FILE: design/wsfp_in_stage.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser input register
// Holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsfp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  wsfp_in_if.sink         in_if,
  input  logic            take,
  output wsfp_pkg::item_t item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;

  assign in_if.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.data_byte;
      end_r  <= in_if.buffer_end;
    end
  end

  assign item.valid      = valid_r;
  assign item.data_byte  = byte_r;
  assign item.buffer_end = end_r;

endmodule

FILE: design/wsfp_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser core
// Per-byte header state machine, unmasking and the result register.
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_unit_assert.svh"

module wsfp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  wsfp_pkg::item_t item,
  output logic            take,
  wsfp_out_if.source      out_if
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DRAIN   = 3'd6
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic                           fin_r, fin_nxt;
  logic [3:0]                     opcode_r, opcode_nxt;
  logic                           mask_r, mask_nxt;
  logic [wsfp_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [wsfp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]                    key_r, key_nxt;
  logic [wsfp_pkg::LEN_W-1:0]     idx_r, idx_nxt;

  logic                           out_valid_r;
  wsfp_pkg::kind_t                out_kind_r;
  logic                           out_fin_r;
  logic [3:0]                     out_opcode_r;
  logic                           out_masked_r;
  logic [wsfp_pkg::OUT_LEN_W-1:0] out_len_r;
  logic [7:0]                     out_byte_r;
  logic                           out_last_r;

  logic                           res_vld;
  wsfp_pkg::kind_t                res_kind;
  logic [7:0]                     res_byte;
  logic                           res_last;
  logic [wsfp_pkg::CNT_W-1:0]     cnt_inc;
  logic [6:0]                     len7;
  logic [7:0]                     key_byte;
  logic [7:0]                     b;

  assign take    = item.valid && (!out_valid_r || out_if.ready);
  assign b       = item.data_byte;
  assign cnt_inc = cnt_r + wsfp_pkg::CNT_W'(1);
  assign len7    = b[6:0] & wsfp_pkg::LEN7_MASK;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    res_vld    = 1'b0;
    res_kind   = wsfp_pkg::KIND_BYTE;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    case (phase_r)
      PH_HDR1: begin
        mask_nxt = b[7];
        cnt_nxt  = '0;
        if (len7 == wsfp_pkg::LEN7_EXT16) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT16;
        end else if (len7 == wsfp_pkg::LEN7_EXT64) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt = wsfp_pkg::LEN_W'(len7);
          if (b[7]) begin
            phase_nxt = PH_KEY;
          end else if (len7 == 7'd0) begin
            phase_nxt = PH_DRAIN;
            res_vld   = 1'b1;
            res_kind  = wsfp_pkg::KIND_DONE;
            res_last  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[wsfp_pkg::LEN_W-9:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= ((phase_r == PH_EXT16) ? wsfp_pkg::EXT16_BYTES
                                              : wsfp_pkg::EXT64_BYTES)) begin
          cnt_nxt = '0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else if (len_nxt == '0) begin
            phase_nxt = PH_DRAIN;
            res_vld   = 1'b1;
            res_kind  = wsfp_pkg::KIND_DONE;
            res_last  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= wsfp_pkg::KEY_BYTES) begin
          cnt_nxt = '0;
          if (len_r == '0) begin
            phase_nxt = PH_DRAIN;
            res_vld   = 1'b1;
            res_kind  = wsfp_pkg::KIND_DONE;
            res_last  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        idx_nxt  = idx_r + wsfp_pkg::LEN_W'(1);
        res_vld  = 1'b1;
        res_kind = wsfp_pkg::KIND_BYTE;
        res_byte = b ^ (mask_r ? key_byte : 8'd0);
        res_last = (idx_nxt >= len_r);
        if (res_last) begin
          phase_nxt = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        fin_nxt    = b[7];
        opcode_nxt = b[3:0] & wsfp_pkg::OPCODE_MASK;
        mask_nxt   = 1'b0;
        len_nxt    = '0;
        cnt_nxt    = '0;
        key_nxt    = '0;
        idx_nxt    = '0;
        phase_nxt  = PH_HDR1;
      end
    endcase
    if (item.buffer_end) begin
      if (phase_nxt != PH_DRAIN && phase_nxt != PH_HDR0) begin
        res_vld  = 1'b1;
        res_kind = wsfp_pkg::KIND_ERROR;
        res_byte = 8'd0;
        res_last = 1'b0;
      end
      phase_nxt = PH_HDR0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      mask_r      <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      key_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        fin_r       <= fin_nxt;
        opcode_r    <= opcode_nxt;
        mask_r      <= mask_nxt;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        key_r       <= key_nxt;
        idx_r       <= idx_nxt;
        out_valid_r <= res_vld;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_vld) begin
      out_kind_r   <= res_kind;
      out_fin_r    <= fin_nxt;
      out_opcode_r <= opcode_nxt;
      out_masked_r <= mask_nxt;
      out_len_r    <= wsfp_pkg::OUT_LEN_W'(len_nxt);
      out_byte_r   <= res_byte;
      out_last_r   <= res_last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.fin          = out_fin_r;
  assign out_if.opcode       = out_opcode_r;
  assign out_if.masked       = out_masked_r;
  assign out_if.frame_len    = out_len_r;
  assign out_if.payload_byte = out_byte_r;
  assign out_if.last         = out_last_r;

  `WSFP_ASSERT_NOW(a_error_fields, out_valid_r && out_kind_r == wsfp_pkg::KIND_ERROR,
    !out_last_r && out_byte_r == 8'd0, "error result must carry no byte and no last")
  `WSFP_ASSERT_NOW(a_done_empty, out_valid_r && out_kind_r == wsfp_pkg::KIND_DONE,
    out_last_r && out_len_r == '0, "completion result must be for an empty frame")
  `WSFP_ASSERT_NOW(a_index_bound, phase_r == PH_PAYLOAD,
    idx_r < len_r, "payload index reached the frame length")
  `WSFP_ASSERT_NEXT(a_end_restart, take && item.buffer_end,
    phase_r == PH_HDR0, "buffer end must restart header parsing")

endmodule

FILE: design/websocket_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Parses one frame from each received buffer and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// The in_if channel takes one buffer byte per transfer, with buffer_end set on
// the buffer's final byte. The out_if channel gives at most one result per
// input byte: a payload byte after unmasking (with the header fields beside
// it), a completion result for a frame with an empty payload, or an error when
// the buffer ends before the frame is complete. Other header and key bytes
// and bytes after a complete frame give no result.
// A byte is registered on input and its result is registered on output. The
// block sustains one byte per cycle while the receiver keeps ready high;
// each byte passes once through the header state machine and the unmasking
// logic between the two registers.
// A synchronous reset on rst_n empties both registers and makes the block
// expect the first header byte of a new frame.
// When the receiver holds ready low, the waiting result stays in the output
// register and the input register still takes one more byte if it is empty;
// after that the in_if ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module websocket_frame_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  wsfp_in_if.sink    in_if,
  wsfp_out_if.source out_if
);

  wsfp_pkg::item_t item;
  logic            take;

  wsfp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (take),
    .item  (item)
  );

  wsfp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .take   (take),
    .out_if (out_if)
  );

endmodule
